>>> sv/kmcs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the key matrix change scanner.
// No dependencies; imported by every module of the block.
package kmcs_pkg;

  localparam int unsigned KEY_W     = 8;
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned NOTE_W    = 8;
  localparam int unsigned BANK_W    = 4;
  localparam int unsigned BIT_IDX_W = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 1;

  localparam logic [NOTE_W-1:0] NOTE_OFFSET = 8'd173;
  localparam logic [NOTE_W-1:0] NOTE_STRIDE = 8'd6;

  typedef enum logic [1:0] {
    EV_NOTE_ON  = 2'd0,
    EV_NOTE_OFF = 2'd1,
    EV_ANALOG   = 2'd2,
    EV_BANK_SEL = 2'd3
  } event_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_INVERT    = 1'b0,
    CFG_ANALOG_REPORT = 1'b1
  } cfg_idx_e;

  // One classified scan tick, as handed from the front end to the back end.
  typedef struct packed {
    logic [KEY_W-1:0]    diff;         // bits that changed against the image
    logic [KEY_W-1:0]    on_mask;      // per bit: 1 = note on, 0 = note off
    logic [BANK_W-1:0]   scan_bank;    // bank that was scanned
    logic [BANK_W-1:0]   new_bank;     // bank selected after the advance
    logic [SAMPLE_W-1:0] sample;
    logic                pulse;        // converter latch pulsed this tick
    logic                analog_emit;  // analog change event owed
  } scan_job_t;

  // Note number: (bank - 6*bit - 173) mod 256.
  function automatic logic [NOTE_W-1:0] note_number(input logic [BANK_W-1:0] bank,
                                                    input logic [BIT_IDX_W-1:0] bit_idx);
    logic [NOTE_W-1:0] step;
    step = NOTE_STRIDE * NOTE_W'(bit_idx);
    return NOTE_W'(bank) - step - NOTE_OFFSET;
  endfunction

  // Index of the lowest set bit; zero for an empty mask.
  function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [KEY_W-1:0] mask);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = KEY_W - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> sv/kmcs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the key matrix change scanner:
// the scan tick input channel and the event output channel. No dependencies.
interface kmcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_bits;
  logic [9:0] analog_sample;

  modport source (output valid, key_bits, analog_sample, input ready);
  modport sink   (input valid, key_bits, analog_sample, output ready);
endinterface

interface kmcs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] note;
  logic [3:0] bank;
  logic [9:0] analog_value;
  logic       latch_pulse;
  logic       last;

  modport source (output valid, event_kind, note, bank, analog_value, latch_pulse, last,
                  input ready);
  modport sink   (input valid, event_kind, note, bank, analog_value, latch_pulse, last,
                  output ready);
endinterface

>>> sv/kmcs_front.sv
`timescale 1ns / 1ps
// Front end: accepts scan ticks, keeps the key and analog images, bank and
// tick counter, and classifies each tick into a job. Depends on kmcs_pkg, kmcs_if.
module kmcs_front import kmcs_pkg::*; #(
  parameter int unsigned ADC_SAMPLE_PERIOD = 4,
  parameter int unsigned NUM_BANKS         = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kmcs_in_if.sink    scan_i,
  input  logic       key_invert_i,
  input  logic       report_en_i,
  input  logic       q_full_i,
  output logic       push_o,
  output scan_job_t  job_o
);

  localparam int unsigned IdxW  = $clog2(NUM_BANKS);
  localparam int unsigned TickW = $clog2(ADC_SAMPLE_PERIOD + 1);

  logic [KEY_W-1:0]    key_img_q [NUM_BANKS];
  logic [SAMPLE_W-1:0] ana_img_q [NUM_BANKS];
  logic [IdxW-1:0]     bank_q, bank_d;
  logic [TickW-1:0]    tick_q, tick_d;
  logic                accept;
  logic                pulse;

  assign scan_i.ready = !q_full_i;
  assign accept       = scan_i.valid && scan_i.ready;
  assign push_o       = accept;

  always_comb begin
    bank_d = (bank_q == IdxW'(NUM_BANKS - 1)) ? '0 : bank_q + IdxW'(1);
    pulse  = (tick_q == TickW'(ADC_SAMPLE_PERIOD - 1));
    tick_d = pulse ? '0 : tick_q + TickW'(1);
  end

  always_comb begin
    job_o.diff        = key_img_q[bank_q] ^ scan_i.key_bits;
    job_o.on_mask     = scan_i.key_bits ^ {KEY_W{key_invert_i}};
    job_o.scan_bank   = BANK_W'(bank_q);
    job_o.new_bank    = BANK_W'(bank_d);
    job_o.sample      = scan_i.analog_sample;
    job_o.pulse       = pulse;
    job_o.analog_emit = pulse && report_en_i && (ana_img_q[bank_d] != scan_i.analog_sample);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= '0;
      tick_q <= '0;
      for (int i = 0; i < NUM_BANKS; i++) begin
        key_img_q[i] <= '0;
        ana_img_q[i] <= '0;
      end
    end else if (accept) begin
      bank_q            <= bank_d;
      tick_q            <= tick_d;
      key_img_q[bank_q] <= scan_i.key_bits;
      if (pulse) begin
        ana_img_q[bank_d] <= scan_i.analog_sample;
      end
    end
  end

endmodule

>>> sv/kmcs_queue.sv
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the back end.
// Depends on kmcs_pkg for the job type.
module kmcs_queue import kmcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  scan_job_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output scan_job_t data_o,
  output logic      valid_o
);

  scan_job_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

>>> sv/kmcs_back.sv
`timescale 1ns / 1ps
// Back end: expands the job at the queue head into note, analog and bank select events,
// one per cycle unless stalled, through an output register. Depends on kmcs_pkg, kmcs_if.
module kmcs_back import kmcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  scan_job_t  head_i,
  input  logic       head_valid_i,
  output logic       pop_o,
  kmcs_out_if.source event_o
);

  logic                 started_q, started_d;
  logic [KEY_W-1:0]     rem_q, rem_d;
  logic                 ana_q, ana_d;
  logic                 valid_q, valid_d;
  event_kind_e          kind_q, kind_d;
  logic [NOTE_W-1:0]    note_q, note_d;
  logic [BANK_W-1:0]    bank_q, bank_d;
  logic [SAMPLE_W-1:0]  value_q, value_d;
  logic                 pulse_q, pulse_d;
  logic                 last_q, last_d;
  logic [KEY_W-1:0]     cur_rem;
  logic                 cur_ana;
  logic [BIT_IDX_W-1:0] bidx;
  logic                 load;

  always_comb begin
    cur_rem   = started_q ? rem_q : head_i.diff;
    cur_ana   = started_q ? ana_q : head_i.analog_emit;
    bidx      = lowest_set(cur_rem);
    load      = head_valid_i && (!valid_q || event_o.ready);
    started_d = started_q;
    rem_d     = rem_q;
    ana_d     = ana_q;
    valid_d   = valid_q && !event_o.ready;
    pop_o     = 1'b0;
    kind_d    = EV_BANK_SEL;
    note_d    = '0;
    bank_d    = '0;
    value_d   = '0;
    pulse_d   = 1'b0;
    last_d    = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      priority if (cur_rem != '0) begin
        kind_d    = head_i.on_mask[bidx] ? EV_NOTE_ON : EV_NOTE_OFF;
        note_d    = note_number(head_i.scan_bank, bidx);
        rem_d     = cur_rem & (cur_rem - KEY_W'(1));
        ana_d     = cur_ana;
        started_d = 1'b1;
      end else if (cur_ana) begin
        kind_d    = EV_ANALOG;
        bank_d    = head_i.new_bank;
        value_d   = head_i.sample;
        rem_d     = '0;
        ana_d     = 1'b0;
        started_d = 1'b1;
      end else begin
        // close the tick and release the queue entry
        kind_d    = EV_BANK_SEL;
        bank_d    = head_i.new_bank;
        pulse_d   = head_i.pulse;
        last_d    = 1'b1;
        started_d = 1'b0;
        pop_o     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      rem_q     <= '0;
      ana_q     <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      started_q <= started_d;
      rem_q     <= rem_d;
      ana_q     <= ana_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind_d;
      note_q  <= note_d;
      bank_q  <= bank_d;
      value_q <= value_d;
      pulse_q <= pulse_d;
      last_q  <= last_d;
    end
  end

  assign event_o.valid        = valid_q;
  assign event_o.event_kind   = kind_q;
  assign event_o.note         = note_q;
  assign event_o.bank         = bank_q;
  assign event_o.analog_value = value_q;
  assign event_o.latch_pulse  = pulse_q;
  assign event_o.last         = last_q;

`ifndef SYNTHESIS
  a_last_on_bank_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == EV_BANK_SEL) |-> last_q)
    else $error("bank select event without last");

  a_no_last_before_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q != EV_BANK_SEL) |-> (!last_q && !pulse_q))
    else $error("last or latch pulse on a non bank select event");

  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> head_valid_i)
    else $error("job left the queue while still being expanded");
`endif

endmodule

>>> sv/key_matrix_change_scanner.sv
`timescale 1ns / 1ps
// Key matrix change scanner, top level. Depends on kmcs_pkg, kmcs_if,
// kmcs_front, kmcs_queue and kmcs_back.
//
// Usage:
//   scan_i carries one scan tick per transaction: the eight key bits of the
//   currently selected bank and a converter sample. event_o returns the
//   tick's events: one note on/off per changed key bit in ascending bit
//   order, then an analog change on sampling ticks when the value moved and
//   reporting is on, then always a bank select with last set.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write key_invert (index 0) and
//   analog_report_enable (index 1); write them only while the block is idle.
// Timing:
//   A tick is accepted and classified on the spot against the key and
//   analog images; its job is written into the queue and then loaded into
//   the back end's output register, which makes the first event valid on event_o.
//   The back end emits one event per cycle while event_o is ready; a tick
//   yields 1 to 10 events (changed bits + analog event + bank select). A two-entry job
//   queue lets new ticks be accepted while earlier ones are still emitted.
// Reset:
//   Clears both images, the bank index and the tick counter, sets
//   key_invert to 0 and analog_report_enable to 1.
// Back-pressure:
//   When event_o is stalled the output register holds; the queue fills and
//   scan_i.ready drops once two ticks are waiting.
module key_matrix_change_scanner import kmcs_pkg::*; #(
  parameter int unsigned ADC_SAMPLE_PERIOD = 4,
  parameter int unsigned NUM_BANKS         = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  kmcs_in_if.sink              scan_i,
  kmcs_out_if.source           event_o
);

  logic      key_invert_q;
  logic      report_en_q;
  logic      q_full;
  logic      push;
  logic      pop;
  logic      head_valid;
  scan_job_t job_in;
  scan_job_t job_head;

  // Configuration registers: plain writes, no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_invert_q <= 1'b0;
      report_en_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_INVERT:    key_invert_q <= cfg_wdata_i[0];
        CFG_ANALOG_REPORT: report_en_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Front end: accept and classify ticks, update images and bank.
  kmcs_front #(
    .ADC_SAMPLE_PERIOD (ADC_SAMPLE_PERIOD),
    .NUM_BANKS         (NUM_BANKS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scan_i       (scan_i),
    .key_invert_i (key_invert_q),
    .report_en_i  (report_en_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (job_in)
  );

  // Decouple classification from event emission.
  kmcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (job_head),
    .valid_o (head_valid)
  );

  // Back end: expand each job into its events, one per cycle while event_o is ready.
  kmcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (job_head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .event_o      (event_o)
  );

endmodule
